### rtl/mhrb_pkg.sv
// ----------------------------------------------------------------------------
// mhrb_pkg
// Shared types and constants for the multichannel history ring buffer core.
// ----------------------------------------------------------------------------
package mhrb_pkg;

	// default sizing of the core
	localparam int CHANNELS_DEF = 4;
	localparam int DEPTH_DEF    = 128;

	// channels reachable through the 2-bit channel field
	localparam int CHAN_PORT_MAX = 4;

	// field widths
	localparam int CMD_W    = 1;
	localparam int CHAN_W   = 2;
	localparam int INDEX_W  = 7;
	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 8;
	localparam int CFG_W    = 8;
	localparam int NCH_W    = 3;
	localparam int REG_IDX_W = 1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_CHANNELS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_DEPTH    = 1'b1;

	// register reset values
	localparam logic [NCH_W-1:0]   CHANNELS_RESET = 3'd4;
	localparam logic [COUNT_W-1:0] DEPTH_RESET    = 8'd100;
	localparam logic [COUNT_W-1:0] DEPTH_MIN      = 8'd2;

	// commands
	localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
	localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

	// per-item decode handed from the channel control to the datapath
	typedef struct packed {
		logic               write_en;
		logic               hit;
		logic [COUNT_W-1:0] count;
	} mhrb_info_t;

endpackage

### rtl/multichannel_history_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// multichannel_history_ring_buffer_core
// Per-channel circular sample history with push and indexed read.
// ----------------------------------------------------------------------------
//  port group   direction  handshake              payload
//  in           sink       in_valid / in_stall    command, channel, point_index, sample
//  out          source     out_valid / out_stall  point_value, fill_count
//  cfg          sink       cfg_wr_en              cfg_index, cfg_data
//
// one word per cycle while in_stall is low; a taken word passes the ram stage, then the output register
// the sample ram port takes at most one access per word, push writes and read reads
// head and count are flops updated at accept, so back-to-back words on one
// channel see each other without forwarding
// out_stall holds the output register, then the ram stage, then in_stall
// reset clears heads, counts, config registers and valid flags; the sample ram and data registers are not cleared
// ----------------------------------------------------------------------------
module multichannel_history_ring_buffer_core
	import mhrb_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int DEPTH    = DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [CHAN_W-1:0]    channel,
	input  logic [INDEX_W-1:0]   point_index,
	input  logic [SAMPLE_W-1:0]  sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SAMPLE_W-1:0]  point_value,
	output logic [COUNT_W-1:0]   fill_count
);

	localparam int NCH = (CHANNELS < CHAN_PORT_MAX) ? CHANNELS : CHAN_PORT_MAX;
	localparam int AW  = $clog2(NCH * DEPTH);

	mhrb_info_t          info;
	logic [AW-1:0]       addr;
	logic                accept;
	logic                adv_s1;
	logic [SAMPLE_W-1:0] rdata;

	logic                valid_s1;
	logic                hit_s1;
	logic [COUNT_W-1:0]  count_s1;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] point_value_q;
	logic [COUNT_W-1:0]  fill_count_q;

	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	mhrb_chan_ctrl #(
		.CHANNELS (CHANNELS),
		.DEPTH    (DEPTH),
		.NCH      (NCH),
		.AW       (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.command     (command),
		.channel     (channel),
		.point_index (point_index),
		.info        (info),
		.addr        (addr)
	);

	mhrb_sample_ram #(
		.ENTRIES (NCH * DEPTH),
		.AW      (AW)
	) u_ram (
		.clk   (clk),
		.we    (accept && info.write_en),
		.re    (accept && info.hit),
		.addr  (addr),
		.wdata (sample),
		.rdata (rdata)
	);

	// ram stage: the read data register holds while this stage is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1   <= info.hit;
			count_s1 <= info.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			point_value_q <= hit_s1 ? rdata : '0;
			fill_count_q  <= count_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign point_value = point_value_q;
	assign fill_count  = fill_count_q;

	// an empty or invalid channel never returns sample data
	a_zero_count_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fill_count == '0) |-> point_value == '0)
		else $error("data returned with zero fill count");

	// a taken word always reaches the ram stage
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word lost before ram stage");

	// input only stalls when the ram stage is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a full pipeline");

	// fill count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(fill_count) <= DEPTH))
		else $error("fill count beyond depth");

endmodule

### rtl/mhrb_sample_ram.sv
// ----------------------------------------------------------------------------
// mhrb_sample_ram
// Single-port sample store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mhrb_sample_ram
	import mhrb_pkg::*;
#(
	parameter int ENTRIES = CHANNELS_DEF * DEPTH_DEF,
	parameter int AW      = $clog2(CHANNELS_DEF * DEPTH_DEF)
) (
	input  logic                clk,
	input  logic                we,
	input  logic                re,
	input  logic [AW-1:0]       addr,
	input  logic [SAMPLE_W-1:0] wdata,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [ENTRIES];
	logic [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/mhrb_chan_ctrl.sv
// ----------------------------------------------------------------------------
// mhrb_chan_ctrl
// Configuration registers, per-channel head and fill count, and the
// address / hit decode for each incoming word.
// ----------------------------------------------------------------------------
module mhrb_chan_ctrl
	import mhrb_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int DEPTH    = DEPTH_DEF,
	parameter int NCH      = (CHANNELS < CHAN_PORT_MAX) ? CHANNELS : CHAN_PORT_MAX,
	parameter int AW       = $clog2(NCH * DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 accept,
	input  logic [CMD_W-1:0]     command,
	input  logic [CHAN_W-1:0]    channel,
	input  logic [INDEX_W-1:0]   point_index,
	output mhrb_info_t           info,
	output logic [AW-1:0]        addr
);

	localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;

	logic [NCH_W-1:0]   chan_q;
	logic [COUNT_W-1:0] depth_q;
	logic [HW-1:0]      head_q [NCH];
	logic [COUNT_W-1:0] cnt_q  [NCH];

	logic [COUNT_W-1:0] act_depth;
	logic               ch_valid;
	logic [CW-1:0]      ch_idx;
	logic               is_push;
	logic [HW-1:0]      head_rd;
	logic [HW-1:0]      head_eff;
	logic [15:0]        head_inc;
	logic [HW-1:0]      head_nxt;
	logic [COUNT_W-1:0] cnt_rd;
	logic [COUNT_W-1:0] cnt_eff;
	logic [COUNT_W-1:0] cnt_nxt;
	logic [8:0]         start;
	logic [8:0]         sum;
	logic [8:0]         slot9;
	logic [HW-1:0]      slot_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q  <= CHANNELS_RESET;
			depth_q <= DEPTH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CHANNELS: chan_q  <= cfg_data[NCH_W-1:0];
				REG_DEPTH:    depth_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// depth saturated to 2 .. DEPTH
	always_comb begin
		if (depth_q < DEPTH_MIN) begin
			act_depth = DEPTH_MIN;
		end else if (32'(depth_q) > DEPTH) begin
			act_depth = COUNT_W'(DEPTH);
		end else begin
			act_depth = depth_q;
		end
	end

	assign ch_valid = ({1'b0, channel} < chan_q) && (32'(channel) < NCH);
	assign ch_idx   = CW'(channel);
	assign is_push  = (command == CMD_PUSH);

	always_comb begin
		head_rd  = head_q[ch_idx];
		head_eff = (16'(head_rd) >= 16'(act_depth)) ? '0 : head_rd;
		head_inc = 16'(head_eff) + 16'd1;
		head_nxt = (head_inc >= 16'(act_depth)) ? '0 : HW'(head_inc);

		cnt_rd  = cnt_q[ch_idx];
		cnt_eff = (cnt_rd > act_depth) ? act_depth : cnt_rd;
		cnt_nxt = (cnt_eff < act_depth) ? cnt_eff + 8'd1 : cnt_eff;

		// full buffer starts at the head, otherwise at slot zero
		start = (cnt_eff < act_depth) ? 9'd0 : 9'(head_eff);
		sum   = start + 9'(point_index);
		slot9 = (sum >= 9'(act_depth)) ? sum - 9'(act_depth) : sum;

		slot_sel = is_push ? head_eff : HW'(slot9);
		addr     = AW'(32'(ch_idx) * DEPTH + 32'(slot_sel));

		info.write_en = ch_valid && is_push;
		info.hit      = ch_valid && !is_push && ({1'b0, point_index} < cnt_eff);
		if (!ch_valid) begin
			info.count = '0;
		end else if (is_push) begin
			info.count = cnt_nxt;
		end else begin
			info.count = cnt_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (accept && info.write_en) begin
			head_q[ch_idx] <= head_nxt;
			cnt_q[ch_idx]  <= cnt_nxt;
		end
	end

endmodule
